@@ rtl/nfsf_pkg.sv @@
// nfsf_pkg: shared types, constants and helpers of the numeric cell split finder
`timescale 1ns / 1ps

package nfsf_pkg;

  // cell length limit and the width of a character position
  localparam int MAX_CELL_LEN = 256;
  localparam int POS_W        = $clog2(MAX_CELL_LEN + 1);

  // fixed field widths
  localparam int CHAR_W       = 8;
  localparam int SPLIT_POS_W  = 9;
  localparam int CFG_IDX_W    = 1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CHAR_AMP       = 8'h26;
  localparam logic [CHAR_W-1:0] CHAR_DOT       = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE      = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_NONE      = 8'h00;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EQN_OPEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EQN_CLOSE = 1'b1;

  // kind of split found
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_AMP   = 2'd1,
    KIND_DOT   = 2'd2,
    KIND_DIGIT = 2'd3
  } split_kind_t;

  // per-cell scan state
  typedef struct packed {
    logic [POS_W-1:0]  count;
    logic              in_eqn;
    logic [CHAR_W-1:0] prev_char;
    logic [POS_W-1:0]  pend_dot_pos;
    logic              pend_dot_valid;
    logic [POS_W-1:0]  amp_pos;
    logic              amp_valid;
    logic [POS_W-1:0]  dot_pos;
    logic              dot_valid;
    logic [POS_W-1:0]  dig_pos;
    logic              dig_valid;
    logic              overflow;
  } scan_state_t;

  // one result item
  typedef struct packed {
    logic                   is_numeric;
    split_kind_t            kind;
    logic [SPLIT_POS_W-1:0] pos;
    logic                   too_long;
  } split_result_t;

  // equation delimiters
  typedef struct packed {
    logic [CHAR_W-1:0] open_char;
    logic [CHAR_W-1:0] close_char;
  } eqn_cfg_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

@@ rtl/nfsf_scan.sv @@
// nfsf_scan: per-item state update and split selection on the end marker
`timescale 1ns / 1ps

module nfsf_scan import nfsf_pkg::*; (
  input  scan_state_t       state,
  input  eqn_cfg_t          cfg,
  input  logic [CHAR_W-1:0] ch,
  input  logic              end_of_field,
  output scan_state_t       state_next,
  output split_result_t     result
);

  logic             d;
  logic             prev_d;
  logic             first;
  logic             dig_ok;
  logic [POS_W-1:0] dig_pos;

  assign d      = is_digit(ch);
  assign prev_d = is_digit(state.prev_char);
  assign first  = (state.count == '0);

  // split selection: ampersand, then dot, then trailing digit
  always_comb begin
    dig_ok  = state.dig_valid;
    dig_pos = state.dig_pos;
    if (!first && prev_d) begin
      dig_ok  = 1'b1;
      dig_pos = state.count;
    end
    result.is_numeric = 1'b0;
    result.kind       = KIND_NONE;
    result.pos        = '0;
    result.too_long   = state.overflow;
    if (state.amp_valid) begin
      result.is_numeric = 1'b1;
      result.kind       = KIND_AMP;
      result.pos        = SPLIT_POS_W'(state.amp_pos);
    end else if (state.dot_valid) begin
      result.is_numeric = 1'b1;
      result.kind       = KIND_DOT;
      result.pos        = SPLIT_POS_W'(state.dot_pos);
    end else if (dig_ok) begin
      result.is_numeric = 1'b1;
      result.kind       = KIND_DIGIT;
      result.pos        = SPLIT_POS_W'(dig_pos);
    end
  end

  // state update for one item
  always_comb begin
    state_next = state;
    if (end_of_field) begin
      state_next = '0;
    end else if (state.count >= POS_W'(MAX_CELL_LEN)) begin
      state_next.overflow = 1'b1;
    end else begin
      // a pending dot is confirmed by a following digit
      if (state.pend_dot_valid && d) begin
        state_next.dot_pos   = state.pend_dot_pos;
        state_next.dot_valid = 1'b1;
      end
      state_next.pend_dot_valid = 1'b0;

      // backslash-ampersand pair
      if (ch == CHAR_AMP && state.prev_char == CHAR_BACKSLASH && !first) begin
        state_next.amp_pos   = state.count - POS_W'(1);
        state_next.amp_valid = 1'b1;
      end

      // dot outside an equation
      if (ch == CHAR_DOT && !state.in_eqn) begin
        if (!first && prev_d) begin
          state_next.dot_pos   = state.count;
          state_next.dot_valid = 1'b1;
        end else begin
          state_next.pend_dot_pos   = state.count;
          state_next.pend_dot_valid = 1'b1;
        end
      end

      // equation tracking
      if (!state.in_eqn) begin
        if (cfg.open_char != CHAR_NONE && ch == cfg.open_char) begin
          state_next.in_eqn = 1'b1;
        end
      end else begin
        if (cfg.close_char != CHAR_NONE && ch == cfg.close_char) begin
          state_next.in_eqn = 1'b0;
        end
      end

      // digit whose following position is outside an equation
      if (d && !state_next.in_eqn) begin
        state_next.dig_pos   = state.count + POS_W'(1);
        state_next.dig_valid = 1'b1;
      end

      state_next.prev_char = ch;
      state_next.count     = state.count + POS_W'(1);
    end
  end

endmodule

@@ rtl/numeric_field_split_finder_core.sv @@
// numeric_field_split_finder_core: top level of the numeric cell split finder
`timescale 1ns / 1ps

// Takes one character of a table cell per item and, on the end-marker item,
// delivers one result item telling where the cell splits into two numeric
// halves (backslash-ampersand, then decimal point, then after the last digit).
// Throughput is one item per cycle while in_stall is low: an item is captured in
// an input register, and the scan state (and, for an end marker, the result
// register) is updated as it moves on. The input side stalls only while the result
// register is full and stalled and an end marker waits behind it. Equation
// delimiters are to be written through the config port only while the block is
// idle; the block does not enforce this. A value of 0 disables that delimiter.

module numeric_field_split_finder_core import nfsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CHAR_W-1:0]      cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      ch,
  input  logic                   end_of_field,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   is_numeric,
  output logic [1:0]             split_kind,
  output logic [SPLIT_POS_W-1:0] split_pos,
  output logic                   too_long
);

  eqn_cfg_t          cfg;
  logic              in_v;
  logic [CHAR_W-1:0] in_ch;
  logic              in_eof;
  logic              advance;
  scan_state_t       state;
  scan_state_t       state_next;
  split_result_t     result;
  split_result_t     result_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EQN_OPEN:  cfg.open_char  <= cfg_data;
        REG_EQN_CLOSE: cfg.close_char <= cfg_data;
        default:       cfg            <= cfg;
      endcase
    end
  end

  // an end marker moves on only when the result register can take it
  assign advance  = in_v && (!in_eof || !out_valid || !out_stall);
  assign in_stall = in_v && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_ch  <= ch;
      in_eof <= end_of_field;
    end
  end

  nfsf_scan u_scan (
    .state        (state),
    .cfg          (cfg),
    .ch           (in_ch),
    .end_of_field (in_eof),
    .state_next   (state_next),
    .result       (result)
  );

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_eof) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_eof) begin
      result_q <= result;
    end
  end

  assign is_numeric = result_q.is_numeric;
  assign split_kind = result_q.kind;
  assign split_pos  = result_q.pos;
  assign too_long   = result_q.too_long;

  // a new result only follows an end marker
  a_result_from_eof: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && in_eof))
    else $error("result item without end marker");

  // state is cleared after an end marker
  a_clear_after_eof: assert property (@(posedge clk) disable iff (rst)
    (advance && in_eof) |=> (state == '0))
    else $error("scan state not cleared after end marker");

  // position counter stays within the cell limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    state.count <= POS_W'(MAX_CELL_LEN))
    else $error("character count beyond cell limit");

  // a non-numeric result carries no split
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_numeric) |-> (split_kind == KIND_NONE && split_pos == '0))
    else $error("non-numeric result with split data");

endmodule
